/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the top-level design file of the mode table block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_HOLDS(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

/* design/mtin_pkg.sv */
// ----------------------------------------------------------------------------
// mtin_pkg
// Types and fixed constants of the mode table interpolate and norm block.
// ----------------------------------------------------------------------------
package mtin_pkg;

   // Field widths fixed by the interface.
   localparam int VAL_W    = 32;
   localparam int RES_W    = 64;
   localparam int MIDX_W   = 4;
   localparam int LOADED_W = 5;
   localparam int LEN_REG_W = 11;

   // Operation codes.
   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_EVAL = 2'd1;
   localparam logic [1:0] OP_NORM = 2'd2;

   // Status codes.
   localparam logic [1:0] STAT_OK         = 2'd0;
   localparam logic [1:0] STAT_FULL       = 2'd1;
   localparam logic [1:0] STAT_NOT_LOADED = 2'd2;

   // Register indexes.
   localparam logic [1:0] REG_LOW  = 2'd0;
   localparam logic [1:0] REG_HIGH = 2'd1;
   localparam logic [1:0] REG_LEN  = 2'd2;

   // Register reset values.
   localparam logic [31:0] RST_LOW  = 32'd0;
   localparam logic [31:0] RST_HIGH = 32'd65536;
   localparam logic [10:0] RST_LEN  = 11'd1024;

   // Multiply-divide unit sizes.
   localparam int MD_A_W = 64;
   localparam int MD_B_W = 32;
   localparam int MD_P_W = MD_A_W + MD_B_W;
   localparam int NORM_SHIFT = 17;
   localparam logic [6:0] MD_MUL_LAST = 7'(MD_B_W - 1);
   localparam logic [6:0] MD_DIV_LAST = 7'(MD_P_W - 1);
   localparam logic [63:0] SAT_POS = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EV_KSTART,
      ST_EV_KWAIT,
      ST_EV_RD0,
      ST_EV_RD1,
      ST_EV_RD2,
      ST_EV_CWAIT,
      ST_NM_WALK,
      ST_NM_DRAIN,
      ST_NM_DSTART,
      ST_NM_DWAIT,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL,
      MD_DIV,
      MD_FIN
   } md_state_type;

   typedef struct packed {
      logic                start;
      logic                shr;
      logic [MD_A_W-1:0]   a;
      logic [MD_B_W-1:0]   b;
      logic [MD_B_W-1:0]   c;
   } md_req_type;

   typedef struct packed {
      logic                done;
      logic [63:0]         quot;
      logic [MD_B_W-1:0]   rem;
   } md_rsp_type;

endpackage

/* design/mode_table_interpolate_and_norm_top.sv */
// ----------------------------------------------------------------------------
// mode_table_interpolate_and_norm_top
// Table of sampled mode vectors with interpolation and trapezoidal norm.
// ----------------------------------------------------------------------------
// Usage: words enter on the req_ channel and one result word leaves on the
// rsp_ channel per request, in order, under valid/ready handshakes. The csr_
// port writes interval_low, interval_high and vector_length; the user must
// write them only while idle, as the block itself does not enforce it.
// A load word appends one sample to the mode being filled.
// An evaluate word runs the shared multiply-divide unit twice (32 multiply
// steps and 96 divide steps each) plus two table reads. A norm word walks
// the mode once, one sample per cycle from the RAM read port, then runs the
// shared unit once. Rejected and out-of-range words go straight to a result.
// Only one word is in flight; req_ready is high while the sequencer is idle.
// A finished result sits in the output register, so the next word is taken
// even while the receiver stalls rsp_ready; a second finished result then
// waits in the sequencer until the output register frees.
// Reset empties the table count and the fill row and restores the registers;
// the sample RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mode_table_interpolate_and_norm_top #(
   parameter int MAX_ROWS  = 1024,
   parameter int MAX_MODES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic signed [31:0] req_sample_value,
   input  logic signed [31:0] req_position,
   input  logic [3:0]  req_mode_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [63:0] rsp_result_value,
   output logic [1:0]  rsp_status,
   output logic [4:0]  rsp_modes_loaded,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import mtin_pkg::*;

   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int MODE_W = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
   localparam int CNT_W  = $clog2(MAX_MODES + 1);
   localparam int ADDR_W = MODE_W + ROW_W;
   localparam int DEPTH  = 2 ** ADDR_W;
   localparam int LEN_W  = $clog2(MAX_ROWS + 1);

   // Configuration registers.
   logic [31:0]          low_ff, high_ff;
   logic [LEN_REG_W-1:0] len_ff;

   // Control and item state.
   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     mode_count_ff, mode_count_in;
   logic [ROW_W-1:0]     load_row_ff, load_row_in;
   logic [31:0]          pos_ff, pos_in;
   logic [MIDX_W-1:0]    midx_ff, midx_in;
   logic [ROW_W-1:0]     k_ff, k_in;
   logic [31:0]          rem_ff, rem_in;
   logic [31:0]          s0_ff, s0_in;
   logic                 neg_ff, neg_in;
   logic [ROW_W-1:0]     walk_ff, walk_in;
   logic                 rd_vld_ff, rd_edge_ff;
   logic                 sq_vld_ff;
   logic [48:0]          sq_ff;
   logic [63:0]          acc_ff, acc_in;
   logic [63:0]          res_value_ff, res_value_in;
   logic [1:0]           res_status_ff, res_status_in;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [63:0]          rsp_value_ff, rsp_value_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [4:0]           rsp_loaded_ff, rsp_loaded_in;

   md_req_type           md_req;
   md_rsp_type           md_rsp;

   logic                 req_fire, out_free;
   logic [LEN_W-1:0]     eff_len;
   logic [ROW_W-1:0]     n_rows;
   logic signed [32:0]   lo_s, hi_s, req_x_s, x_s;
   logic [32:0]          span_w, dist_w;
   logic                 outside, empty_iv, not_loaded, table_full, row_last;
   logic [MODE_W+MIDX_W-1:0] midx_wide;
   logic [MODE_W+CNT_W-1:0]  cnt_wide;
   logic [LOADED_W+CNT_W-1:0] loaded_wide;
   logic [MODE_W-1:0]    midx_sel, cnt_sel;
   logic                 ram_we;
   logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
   logic [31:0]          ram_rdata;
   logic [32:0]          diff_w, mag_w;
   logic [31:0]          sq_mag;
   logic [63:0]          sq_full;
   logic [64:0]          acc_sum;
   logic [63:0]          s0_ext;

   // Effective vector length, clamped to two and the row count.
   always_comb begin
      if (32'(len_ff) < 32'd2) begin
         eff_len = LEN_W'(2);
      end else if (32'(len_ff) > 32'(MAX_ROWS)) begin
         eff_len = LEN_W'(MAX_ROWS);
      end else begin
         eff_len = LEN_W'(len_ff);
      end
   end
   assign n_rows = ROW_W'(32'(eff_len) - 32'd1);

   // Interval arithmetic on sign-extended Q16.16 values.
   assign lo_s     = {low_ff[31], low_ff};
   assign hi_s     = {high_ff[31], high_ff};
   assign req_x_s  = {req_position[31], req_position};
   assign x_s      = {pos_ff[31], pos_ff};
   assign span_w   = 33'(hi_s - lo_s);
   assign dist_w   = 33'(x_s - lo_s);
   assign outside  = (req_x_s <= lo_s) || (req_x_s >= hi_s);
   assign empty_iv = (hi_s <= lo_s);

   // Table bookkeeping.
   assign req_fire    = req_valid && req_ready;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign not_loaded  = (32'(req_mode_index) >= 32'(mode_count_ff));
   assign table_full  = (32'(mode_count_ff) >= 32'(MAX_MODES));
   assign row_last    = (32'(load_row_ff) + 32'd1 >= 32'(eff_len));
   assign midx_wide   = {{MODE_W{1'b0}}, midx_ff};
   assign midx_sel    = midx_wide[MODE_W-1:0];
   assign cnt_wide    = {{MODE_W{1'b0}}, mode_count_ff};
   assign cnt_sel     = cnt_wide[MODE_W-1:0];
   assign loaded_wide = {{LOADED_W{1'b0}}, mode_count_ff};

   // Sample RAM: loads write, evaluate and norm read.
   assign ram_we    = req_fire && (req_mode == OP_LOAD) && !table_full;
   assign ram_waddr = {cnt_sel, load_row_ff};

   always_comb begin
      case (state_ff)
         ST_EV_RD0: ram_raddr = {midx_sel, k_ff};
         ST_EV_RD1: ram_raddr = {midx_sel, ROW_W'(k_ff + 1'b1)};
         default:   ram_raddr = {midx_sel, walk_ff};
      endcase
   end

   mtin_ram #(
      .WIDTH (VAL_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_sample_value),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Shared multiply-divide unit.
   mtin_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .req   (md_req),
      .rsp   (md_rsp)
   );

   // Difference of neighboring samples for the interpolation.
   assign diff_w = {ram_rdata[31], ram_rdata} - {s0_ff[31], s0_ff};
   assign mag_w  = diff_w[32] ? 33'(-diff_w) : diff_w;
   assign s0_ext = {{32{s0_ff[31]}}, s0_ff};

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_mode)
                  OP_EVAL: state_in = (not_loaded || outside) ? ST_DONE : ST_EV_KSTART;
                  OP_NORM: state_in = (not_loaded || empty_iv) ? ST_DONE : ST_NM_WALK;
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_EV_KSTART: state_in = ST_EV_KWAIT;
         ST_EV_KWAIT:  if (md_rsp.done) state_in = ST_EV_RD0;
         ST_EV_RD0:    state_in = ST_EV_RD1;
         ST_EV_RD1:    state_in = ST_EV_RD2;
         ST_EV_RD2:    state_in = ST_EV_CWAIT;
         ST_EV_CWAIT:  if (md_rsp.done) state_in = ST_DONE;
         ST_NM_WALK:   if (walk_ff == n_rows) state_in = ST_NM_DRAIN;
         ST_NM_DRAIN:  if (!rd_vld_ff && !sq_vld_ff) state_in = ST_NM_DSTART;
         ST_NM_DSTART: state_in = ST_NM_DWAIT;
         ST_NM_DWAIT:  if (md_rsp.done) state_in = ST_DONE;
         ST_DONE:      if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer: handshake and unit requests.
   always_comb begin
      req_ready    = (state_ff == ST_IDLE);
      md_req.start = 1'b0;
      md_req.shr   = 1'b0;
      md_req.a     = MD_A_W'(n_rows);
      md_req.b     = dist_w[31:0];
      md_req.c     = span_w[31:0];
      case (state_ff)
         ST_EV_KSTART: begin
            md_req.start = 1'b1;
         end
         ST_EV_RD2: begin
            md_req.start = 1'b1;
            md_req.a     = MD_A_W'(mag_w);
            md_req.b     = rem_ff;
         end
         ST_NM_DSTART: begin
            md_req.start = 1'b1;
            md_req.shr   = 1'b1;
            md_req.a     = acc_ff;
            md_req.b     = span_w[31:0];
            md_req.c     = 32'(n_rows);
         end
         default: begin
            md_req.start = 1'b0;
         end
      endcase
   end

   // Square of each walked sample, weighted one at the ends and two inside.
   assign sq_mag  = ram_rdata[31] ? 32'(-ram_rdata) : ram_rdata;
   assign sq_full = 64'(sq_mag) * 64'(sq_mag);
   assign acc_sum = {1'b0, acc_ff} + 65'(sq_ff);

   // Datapath next values.
   always_comb begin
      mode_count_in = mode_count_ff;
      load_row_in   = load_row_ff;
      pos_in        = pos_ff;
      midx_in       = midx_ff;
      k_in          = k_ff;
      rem_in        = rem_ff;
      s0_in         = s0_ff;
      neg_in        = neg_ff;
      walk_in       = walk_ff;
      acc_in        = acc_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               pos_in       = req_position;
               midx_in      = req_mode_index;
               walk_in      = '0;
               acc_in       = '0;
               res_value_in = '0;
               case (req_mode)
                  OP_LOAD: begin
                     res_status_in = table_full ? STAT_FULL : STAT_OK;
                     if (!table_full) begin
                        if (row_last) begin
                           load_row_in   = '0;
                           mode_count_in = mode_count_ff + 1'b1;
                        end else begin
                           load_row_in = load_row_ff + 1'b1;
                        end
                     end
                  end
                  OP_EVAL, OP_NORM: begin
                     res_status_in = not_loaded ? STAT_NOT_LOADED : STAT_OK;
                  end
                  default: begin
                     res_status_in = STAT_OK;
                  end
               endcase
            end
         end
         ST_EV_KWAIT: begin
            if (md_rsp.done) begin
               rem_in = md_rsp.rem;
               if (md_rsp.quot >= 64'(n_rows)) begin
                  k_in = n_rows - 1'b1;
               end else begin
                  k_in = md_rsp.quot[ROW_W-1:0];
               end
            end
         end
         ST_EV_RD1: begin
            s0_in = ram_rdata;
         end
         ST_EV_RD2: begin
            neg_in = diff_w[32];
         end
         ST_EV_CWAIT: begin
            if (md_rsp.done) begin
               res_value_in = neg_ff ? (s0_ext - md_rsp.quot) : (s0_ext + md_rsp.quot);
            end
         end
         ST_NM_WALK: begin
            walk_in = walk_ff + 1'b1;
         end
         ST_NM_DWAIT: begin
            if (md_rsp.done) res_value_in = md_rsp.quot;
         end
         default: begin
            walk_in = walk_ff;
         end
      endcase
      // Saturating accumulation runs behind the walk.
      if (sq_vld_ff) begin
         acc_in = acc_sum[64] ? '1 : acc_sum[63:0];
      end
   end

   // Output register loads from the sequencer when it is free.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_loaded_in = rsp_loaded_ff;
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = res_value_ff;
         rsp_status_in = res_status_ff;
         rsp_loaded_in = loaded_wide[LOADED_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mode_count_ff <= '0;
         load_row_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         rd_vld_ff     <= 1'b0;
         sq_vld_ff     <= 1'b0;
         low_ff        <= RST_LOW;
         high_ff       <= RST_HIGH;
         len_ff        <= RST_LEN;
      end else begin
         state_ff      <= state_in;
         mode_count_ff <= mode_count_in;
         load_row_ff   <= load_row_in;
         rsp_valid_ff  <= rsp_valid_in;
         rd_vld_ff     <= (state_ff == ST_NM_WALK);
         sq_vld_ff     <= rd_vld_ff;
         if (csr_we) begin
            case (csr_index)
               REG_LOW:  low_ff  <= csr_wdata;
               REG_HIGH: high_ff <= csr_wdata;
               REG_LEN:  len_ff  <= csr_wdata[LEN_REG_W-1:0];
               default:  len_ff  <= len_ff;
            endcase
         end
      end
      pos_ff        <= pos_in;
      midx_ff       <= midx_in;
      k_ff          <= k_in;
      rem_ff        <= rem_in;
      s0_ff         <= s0_in;
      neg_ff        <= neg_in;
      walk_ff       <= walk_in;
      acc_ff        <= acc_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rd_edge_ff    <= (walk_ff == '0) || (walk_ff == n_rows);
      sq_ff         <= rd_edge_ff ? {1'b0, sq_full[63:16]} : {sq_full[63:16], 1'b0};
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_loaded_ff <= rsp_loaded_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_modes_loaded = rsp_loaded_ff;

   // The shared unit only finishes while the sequencer waits for it.
   `ASSERT_HOLDS(a_md_done_wait, clock, reset, md_rsp.done, (state_ff == ST_EV_KWAIT) || (state_ff == ST_EV_CWAIT) || (state_ff == ST_NM_DWAIT), "muldiv finished outside a wait state")
   // The mode count never passes the table size.
   `ASSERT_HOLDS(a_count_bound, clock, reset, 1'b1, 32'(mode_count_ff) <= 32'(MAX_MODES), "mode count beyond table size")
   // A load that fills the last row completes exactly one mode.
   `ASSERT_NEXT(a_mode_done, clock, reset, req_fire && (req_mode == OP_LOAD) && !table_full && row_last, (mode_count_ff == CNT_W'($past(mode_count_ff) + 1'b1)) && (load_row_ff == '0), "completed load did not advance mode count")

endmodule

/* design/mtin_ram.sv */
// ----------------------------------------------------------------------------
// mtin_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mtin_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/mtin_muldiv.sv */
// ----------------------------------------------------------------------------
// mtin_muldiv
// Shared bit-serial unit computing floor((a*b >> s) / c), s being 0 or 17.
// ----------------------------------------------------------------------------
module mtin_muldiv (
   input  logic               clock,
   input  logic               reset,
   input  mtin_pkg::md_req_type req,
   output mtin_pkg::md_rsp_type rsp
);
   import mtin_pkg::*;

   md_state_type      state_ff, state_in;
   logic [MD_A_W-1:0] a_ff, a_in;
   logic [MD_B_W-1:0] b_ff, b_in;
   logic [MD_B_W-1:0] c_ff, c_in;
   logic              shr_ff, shr_in;
   logic [MD_P_W-1:0] p_ff, p_in;
   logic [MD_B_W-1:0] r_ff, r_in;
   logic [6:0]        cnt_ff, cnt_in;

   logic [MD_P_W-1:0] mul_sum;
   logic [MD_B_W:0]   r_shift;
   logic              r_ge;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         MD_IDLE: begin
            if (req.start) state_in = MD_MUL;
         end
         MD_MUL: begin
            if (cnt_ff == MD_MUL_LAST) state_in = MD_DIV;
         end
         MD_DIV: begin
            if (cnt_ff == MD_DIV_LAST) state_in = MD_FIN;
         end
         MD_FIN: begin
            state_in = MD_IDLE;
         end
         default: begin
            state_in = MD_IDLE;
         end
      endcase
   end

   // Outputs. The quotient saturates at the largest positive value.
   always_comb begin
      rsp.done = (state_ff == MD_FIN);
      rsp.rem  = r_ff;
      if (|p_ff[MD_P_W-1:63]) begin
         rsp.quot = SAT_POS;
      end else begin
         rsp.quot = {1'b0, p_ff[62:0]};
      end
   end

   // One shift-add step of the multiply and one restoring step of the divide.
   assign mul_sum = {p_ff[MD_P_W-2:0], 1'b0} + (b_ff[MD_B_W-1] ? MD_P_W'(a_ff) : '0);
   assign r_shift = {r_ff, p_ff[MD_P_W-1]};
   assign r_ge    = (r_shift >= {1'b0, c_ff});

   always_comb begin
      a_in   = a_ff;
      b_in   = b_ff;
      c_in   = c_ff;
      shr_in = shr_ff;
      p_in   = p_ff;
      r_in   = r_ff;
      cnt_in = cnt_ff;
      case (state_ff)
         MD_IDLE: begin
            a_in   = req.a;
            b_in   = req.b;
            c_in   = req.c;
            shr_in = req.shr;
            p_in   = '0;
            cnt_in = '0;
         end
         MD_MUL: begin
            b_in   = {b_ff[MD_B_W-2:0], 1'b0};
            cnt_in = cnt_ff + 7'd1;
            p_in   = mul_sum;
            if (cnt_ff == MD_MUL_LAST) begin
               // The norm drops 17 fraction bits before the divide.
               p_in   = shr_ff ? (mul_sum >> NORM_SHIFT) : mul_sum;
               r_in   = '0;
               cnt_in = '0;
            end
         end
         MD_DIV: begin
            cnt_in = cnt_ff + 7'd1;
            p_in   = {p_ff[MD_P_W-2:0], r_ge};
            r_in   = r_ge ? MD_B_W'(r_shift - {1'b0, c_ff}) : r_shift[MD_B_W-1:0];
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      shr_ff <= shr_in;
      p_ff   <= p_in;
      r_ff   <= r_in;
   end

endmodule
